>>> rtl/tgr_pkg.sv
// shared types, constants and the 8x8 glyph tables of the text glyph rasterizer
// no dependencies; imported by every module of the block
package tgr_pkg;

    localparam int GLYPH_ROWS  = 8;
    localparam int GLYPH_COLS  = 8;
    localparam int GLYPH_COUNT = 80;
    localparam int MAX_CELLS   = 256;
    localparam int ROM_SIZE    = 80;

    localparam int BITMAP_W = GLYPH_ROWS * GLYPH_COLS;
    localparam int POS_W    = $clog2(BITMAP_W);

    localparam int COORD_W  = 16;
    localparam int COLOR_W  = 8;
    localparam int CELL_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes of the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Q8  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INK_COLOR = 3'd3;

    localparam logic [15:0] SCALE_RESET = 16'd256;
    localparam logic [7:0]  INK_RESET   = 8'd1;

    typedef struct packed {
        logic load;
        logic step;
    } tgr_cmd_t;

    typedef struct packed {
        logic adv;
        logic sh_zero;
        logic rest_zero;
    } tgr_status_t;

    typedef struct packed {
        logic       hit;
        logic [6:0] idx;
    } tgr_glyph_t;

    // character code to glyph slot
    function automatic tgr_glyph_t glyph_lookup(input logic [7:0] code);
        tgr_glyph_t g;
        g.hit = 1'b1;
        g.idx = '0;
        priority if (code >= 8'h30 && code <= 8'h39) begin
            g.idx = 7'(code - 8'h30 + 8'd1);
        end else if (code >= 8'h61 && code <= 8'h7a) begin
            g.idx = 7'(code - 8'h61 + 8'd11);
        end else if (code >= 8'h41 && code <= 8'h5a) begin
            g.idx = 7'(code - 8'h41 + 8'd37);
        end else begin
            unique case (code)
                8'h20: g.idx = 7'd0;
                8'h2e: g.idx = 7'd63;
                8'h2c: g.idx = 7'd64;
                8'h3a: g.idx = 7'd65;
                8'h21: g.idx = 7'd66;
                8'h2f: g.idx = 7'd67;
                8'h5c: g.idx = 7'd68;
                8'h7c: g.idx = 7'd69;
                8'h2b: g.idx = 7'd70;
                8'h2d: g.idx = 7'd71;
                8'h2a: g.idx = 7'd72;
                8'h3d: g.idx = 7'd73;
                8'h28: g.idx = 7'd74;
                8'h29: g.idx = 7'd75;
                8'h5b: g.idx = 7'd76;
                8'h5d: g.idx = 7'd77;
                8'h7b: g.idx = 7'd78;
                8'h7d: g.idx = 7'd79;
                default: g.hit = 1'b0;
            endcase
        end
        if (32'(g.idx) >= GLYPH_COUNT || 32'(g.idx) >= ROM_SIZE) begin
            g.hit = 1'b0;
        end
        return g;
    endfunction

    // glyph bitmaps, row 0 in the lowest byte, bit 0 of each byte the leftmost column
    function automatic logic [BITMAP_W-1:0] glyph_bitmap(input logic [6:0] idx);
        logic [BITMAP_W-1:0] b;
        unique case (idx)
            7'd0:  b = 64'h0000_0000_0000_0000;
            7'd1:  b = 64'h003E_4345_4951_613E;
            7'd2:  b = 64'h0040_4040_4040_6040;
            7'd3:  b = 64'h007F_0102_3C40_413E;
            7'd4:  b = 64'h003E_4140_3C40_413E;
            7'd5:  b = 64'h0020_2020_7E21_2121;
            7'd6:  b = 64'h003E_4140_3E01_017F;
            7'd7:  b = 64'h003E_4141_3F01_013E;
            7'd8:  b = 64'h0002_0408_1020_407E;
            7'd9:  b = 64'h003E_4141_3E41_413E;
            7'd10: b = 64'h003E_4040_7E41_413E;
            7'd11: b = 64'h005E_213E_201E_0000;
            7'd12: b = 64'h003D_4242_3E02_0202;
            7'd13: b = 64'h001C_2202_221C_0000;
            7'd14: b = 64'h005E_2121_3E20_2020;
            7'd15: b = 64'h001E_013F_211E_0000;
            7'd16: b = 64'h0002_0202_0F02_021C;
            7'd17: b = 64'h1E20_3E21_213E_0000;
            7'd18: b = 64'h0023_2222_1E02_0202;
            7'd19: b = 64'h001F_0404_0600_0400;
            7'd20: b = 64'h0609_0808_0800_0800;
            7'd21: b = 64'h0022_120A_060A_1200;
            7'd22: b = 64'h000F_0404_0404_0406;
            7'd23: b = 64'h0049_4949_4B35_0000;
            7'd24: b = 64'h0022_2222_261A_0000;
            7'd25: b = 64'h001E_2121_211E_0000;
            7'd26: b = 64'h0302_1E22_221F_0000;
            7'd27: b = 64'h6020_1E21_215E_0000;
            7'd28: b = 64'h0003_0202_261B_0000;
            7'd29: b = 64'h001F_201E_011E_0000;
            7'd30: b = 64'h0018_0404_1F04_0400;
            7'd31: b = 64'h005E_2121_2121_0000;
            7'd32: b = 64'h0008_1422_2241_0000;
            7'd33: b = 64'h0036_4949_4141_0000;
            7'd34: b = 64'h0021_120C_1221_0000;
            7'd35: b = 64'h0E19_2422_2222_0000;
            7'd36: b = 64'h007E_0408_103F_0000;
            7'd37: b = 64'h0041_417F_4122_1408;
            7'd38: b = 64'h001F_2121_1F21_211F;
            7'd39: b = 64'h001C_2201_0101_221C;
            7'd40: b = 64'h000F_1121_2121_110F;
            7'd41: b = 64'h003F_0101_1F01_013F;
            7'd42: b = 64'h0001_0101_1F01_013F;
            7'd43: b = 64'h005C_6271_0101_221C;
            7'd44: b = 64'h0041_4141_7F41_4141;
            7'd45: b = 64'h001F_0404_0404_041F;
            7'd46: b = 64'h0205_0404_0404_041F;
            7'd47: b = 64'h0021_1109_0709_1121;
            7'd48: b = 64'h003F_0101_0101_0101;
            7'd49: b = 64'h0041_4141_4149_5563;
            7'd50: b = 64'h0041_6151_4945_4341;
            7'd51: b = 64'h001C_2241_4141_221C;
            7'd52: b = 64'h0001_0101_0F11_110F;
            7'd53: b = 64'h601C_2A45_4141_221C;
            7'd54: b = 64'h0021_2111_0F11_110F;
            7'd55: b = 64'h001C_2210_0804_221C;
            7'd56: b = 64'h0008_0808_0808_087F;
            7'd57: b = 64'h001C_2241_4141_4141;
            7'd58: b = 64'h0008_1414_2222_4141;
            7'd59: b = 64'h0022_5549_4141_4141;
            7'd60: b = 64'h0041_4122_1C22_4141;
            7'd61: b = 64'h0008_0808_1422_4141;
            7'd62: b = 64'h007F_0204_0810_207F;
            7'd63: b = 64'h0008_0000_0000_0000;
            7'd64: b = 64'h0810_1000_0000_0000;
            7'd65: b = 64'h0008_0000_0800_0000;
            7'd66: b = 64'h0008_0008_0808_0808;
            7'd67: b = 64'h0001_0204_0810_2040;
            7'd68: b = 64'h0040_2010_0804_0201;
            7'd69: b = 64'h0808_0808_0808_0808;
            7'd70: b = 64'h0000_0808_3E08_0800;
            7'd71: b = 64'h0000_0000_3E00_0000;
            7'd72: b = 64'h0000_2A1C_081C_2A00;
            7'd73: b = 64'h0000_003E_003E_0000;
            7'd74: b = 64'h000C_0201_0101_020C;
            7'd75: b = 64'h0018_2040_4040_2018;
            7'd76: b = 64'h0003_0101_0101_0103;
            7'd77: b = 64'h0060_4040_4040_4060;
            7'd78: b = 64'h0002_0101_0301_0102;
            7'd79: b = 64'h0020_4040_6040_4020;
            default: b = '0;
        endcase
        return b;
    endfunction

endpackage

>>> rtl/text_glyph_rasterizer.sv
// channel  | direction | handshake                      | payload
// s_axis   | in        | s_axis_tvalid / s_axis_tready  | tdata char_code, tuser first_of_string
// m_axis   | out       | m_axis_tvalid / m_axis_tready  | tdata coords+color, tuser is_box, tlast
// cfg      | in        | cfg_valid / cfg_ready          | cfg_index, cfg_data
//
// a character is accepted only while no scan runs, then scanned one bitmap bit per step up to
// its highest set bit; a step waits while the output is stalled, a blank or unknown code ends the scan
// draw commands pass the multiply stage and output registers after their scan step, at most one per cycle
// a stalled output freezes the scan shifter and the multiply stage together
// synchronous active-low reset clears the config to its defaults and the cell position
// top level of the text glyph rasterizer; depends on tgr_pkg, tgr_ctrl, tgr_datapath
module text_glyph_rasterizer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tgr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tgr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // [7:0] char_code
    input  logic                           s_axis_tuser,  // [0] first_of_string
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [15:0] x_start, [31:16] y_start, [47:32] x_end, [63:48] y_end, [71:64] color
    output logic [71:0]                    m_axis_tdata,
    output logic                           m_axis_tuser,  // [0] is_box
    output logic                           m_axis_tlast
);
    import tgr_pkg::*;

    tgr_cmd_t    cmd;
    tgr_status_t st;

    assign cfg_ready = 1'b1;

    tgr_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .st            (st),
        .cmd           (cmd)
    );

    tgr_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd           (cmd),
        .st            (st),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

>>> rtl/tgr_ctrl.sv
// sequencer of the text glyph rasterizer: accepts a character, then scans its bitmap
// depends on tgr_pkg for the command and status structs
module tgr_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  tgr_pkg::tgr_status_t st,
    output tgr_pkg::tgr_cmd_t    cmd
);
    import tgr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } tgr_state_t;

    tgr_state_t state_reg, state_next;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cmd.load      = s_axis_tvalid && s_axis_tready;
    assign cmd.step      = (state_reg == ST_SCAN) && st.adv;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.load) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // blank or unknown glyph, or the final set bit moves on
                if (st.sh_zero || (cmd.step && st.rest_zero)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_empty_exits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && st.sh_zero) |=> (state_reg == ST_IDLE))
        else $error("scan did not end on an empty bitmap");
    a_no_load_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> !cmd.load)
        else $error("character taken while scanning");
    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("sequencer state is not one-hot");
`endif

endmodule

>>> rtl/tgr_datapath.sv
// datapath of the text glyph rasterizer: config registers, cell counter, bitmap
// shifter, scale multiply stage and output register; depends on tgr_pkg
module tgr_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    input  logic [tgr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tgr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [7:0]                       s_axis_tdata,
    input  logic                             s_axis_tuser,
    input  tgr_pkg::tgr_cmd_t                cmd,
    output tgr_pkg::tgr_status_t             st,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [71:0]                      m_axis_tdata,
    output logic                             m_axis_tuser,
    output logic                             m_axis_tlast
);
    import tgr_pkg::*;

    localparam int XO_W = CELL_W + 3;
    localparam int PX_W = XO_W + COORD_W;
    localparam int PY_W = 4 + COORD_W;

    // configuration
    logic [COORD_W-1:0] origin_x_reg, origin_y_reg, scale_reg;
    logic [COLOR_W-1:0] ink_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            scale_reg    <= SCALE_RESET;
            ink_reg      <= INK_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ORIGIN_X:  origin_x_reg <= cfg_data;
                CFG_ORIGIN_Y:  origin_y_reg <= cfg_data;
                CFG_SCALE_Q8:  scale_reg    <= cfg_data;
                CFG_INK_COLOR: ink_reg      <= cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    logic               box;
    logic [7:0]         whole;
    assign box   = scale_reg > 16'd256;
    assign whole = scale_reg[15:8];

    // cell counter and bitmap scan
    logic [CELL_W-1:0]   cell_pos_reg, cell_pos_next;
    logic [CELL_W-1:0]   cell_reg, cell_cur;
    logic [BITMAP_W-1:0] sh_reg, sh_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    tgr_glyph_t          glyph;

    assign glyph    = glyph_lookup(s_axis_tdata);
    assign cell_cur = s_axis_tuser ? '0 : cell_pos_reg;

    always_comb begin
        cell_pos_next = cell_pos_reg;
        sh_next       = sh_reg;
        pos_next      = pos_reg;
        if (cmd.load) begin
            cell_pos_next = (cell_cur == CELL_W'(MAX_CELLS - 1)) ? '0 : cell_cur + 1'b1;
            sh_next       = glyph.hit ? glyph_bitmap(glyph.idx) : '0;
            pos_next      = '0;
        end else if (cmd.step) begin
            sh_next  = sh_reg >> 1;
            pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_pos_reg <= '0;
            sh_reg       <= '0;
            pos_reg      <= '0;
        end else begin
            cell_pos_reg <= cell_pos_next;
            sh_reg       <= sh_next;
            pos_reg      <= pos_next;
        end
        if (cmd.load) begin
            cell_reg <= cell_cur;
        end
    end

    logic          adv;
    logic          emit;
    logic          rest_zero;
    logic [XO_W-1:0] xo;
    logic [3:0]    yo;

    assign adv       = !m_axis_tvalid || m_axis_tready;
    assign rest_zero = (sh_reg[BITMAP_W-1:1] == '0);
    assign emit      = cmd.step && sh_reg[0];
    assign xo        = {cell_reg, pos_reg[2:0]};
    // rows are drawn upside down
    assign yo        = 4'd8 - {1'b0, pos_reg[POS_W-1:3]};

    assign st.adv       = adv;
    assign st.sh_zero   = (sh_reg == '0);
    assign st.rest_zero = rest_zero;

    // multiply stage
    logic                s1_valid_reg;
    logic                s1_last_reg, s1_box_reg;
    logic [PX_W-1:0]     s1_px_reg;
    logic [PY_W-1:0]     s1_py_reg;
    logic [XO_W-1:0]     s1_xo_reg;
    logic [3:0]          s1_yo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= emit;
        end
        if (emit) begin
            s1_px_reg   <= {{COORD_W{1'b0}}, xo} * {{XO_W{1'b0}}, scale_reg};
            s1_py_reg   <= {{COORD_W{1'b0}}, yo} * {4'b0, scale_reg};
            s1_xo_reg   <= xo;
            s1_yo_reg   <= yo;
            s1_last_reg <= rest_zero;
            s1_box_reg  <= box;
        end
    end

    // coordinate stage into the output register
    logic [COORD_W-1:0] xs, ys, xe, ye;

    always_comb begin
        if (s1_box_reg) begin
            xs = origin_x_reg + s1_px_reg[COORD_W+7:8];
            ys = origin_y_reg + {4'b0, s1_py_reg[PY_W-1:8]};
            xe = xs + {8'b0, whole};
            ye = ys + {8'b0, whole};
        end else begin
            xs = origin_x_reg + {{(COORD_W-XO_W){1'b0}}, s1_xo_reg};
            ys = origin_y_reg + {12'b0, s1_yo_reg};
            xe = xs;
            ye = ys;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tvalid <= 1'b0;
        end else if (adv) begin
            m_axis_tvalid <= s1_valid_reg;
        end
        if (adv && s1_valid_reg) begin
            m_axis_tdata <= {ink_reg, ye, xe, ys, xs};
            m_axis_tuser <= s1_box_reg;
            m_axis_tlast <= s1_last_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_load_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> (sh_reg == '0))
        else $error("new character loaded over an unfinished bitmap");
    a_pixel_extent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |->
            (m_axis_tdata[47:32] == m_axis_tdata[15:0] &&
             m_axis_tdata[63:48] == m_axis_tdata[31:16]))
        else $error("pixel command with a non-zero extent");
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !adv) |=> s1_valid_reg)
        else $error("multiply stage dropped a command under stall");
`endif

endmodule
